/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// assertion macros shared by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define BQS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, held off during reset
`define BQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* design/bqs_pkg.sv */
// ----------------------------------------------------------------------------
// bqs_pkg
// shared constants, types and codes of the byte quantile select block
// ----------------------------------------------------------------------------
package bqs_pkg;

   // run length limit default
   localparam int MAX_SAMPLES = 4096;

   // sample and histogram geometry
   localparam int SAMPLE_W = 8;
   localparam int NUM_BINS = 1 << SAMPLE_W;

   // ratio registers
   localparam int RATIO_W = 16;
   localparam logic [RATIO_W-1:0] RATIO_NUM_RESET = 16'd1;
   localparam logic [RATIO_W-1:0] RATIO_DEN_RESET = 16'd2;

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_NUM = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_DEN = 1'b1;

   // sequencer states
   typedef enum logic [4:0] {
      ST_COLLECT = 5'b00001,
      ST_CALC    = 5'b00010,
      ST_SCAN    = 5'b00100,
      ST_DRAIN   = 5'b01000,
      ST_FINISH  = 5'b10000
   } bqs_state_type;

   // control from the sequencer to the rank scan
   typedef struct packed {
      logic                start;
      logic                shift;
      logic [SAMPLE_W-1:0] bin;
   } bqs_scan_ctrl_type;

endpackage

/* design/bqs_cell.sv */
// ----------------------------------------------------------------------------
// bqs_cell
// one histogram bin: counts matching samples, shifts toward the chain head
// during the rank scan
// ----------------------------------------------------------------------------
module bqs_cell #(
   parameter int CNT_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             hit,
   input  logic             shift,
   input  logic [CNT_W-1:0] shift_in,
   output logic [CNT_W-1:0] count
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // shift wins over counting; the two never overlap
   always_comb begin
      if (shift) begin
         count_in = shift_in;
      end else if (hit) begin
         count_in = count_ff + CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

/* design/bqs_rank_scan.sv */
// ----------------------------------------------------------------------------
// bqs_rank_scan
// running sum over the bins leaving the chain head, compared against the
// rank target without a divider: run > floor(n*num/den) iff run*den > n*num
// ----------------------------------------------------------------------------
module bqs_rank_scan #(
   parameter int CNT_W = 13
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bqs_pkg::bqs_scan_ctrl_type           ctrl,
   input  logic [CNT_W-1:0]                     head_count,
   input  logic [CNT_W-1:0]                     run_count,
   input  logic [bqs_pkg::RATIO_W-1:0]          ratio_num,
   input  logic [bqs_pkg::RATIO_W-1:0]          ratio_den,
   output logic [bqs_pkg::SAMPLE_W-1:0]         rank_value
);

   localparam int PROD_W = CNT_W + bqs_pkg::RATIO_W;

   logic                            ratio_ge;
   logic [bqs_pkg::RATIO_W-1:0]     mden_ff;
   logic [PROD_W-1:0]               target_ff;
   logic [PROD_W-1:0]               target_in;
   logic [CNT_W-1:0]                run_ff;
   logic [CNT_W-1:0]                run_in;
   logic                            va_ff;
   logic                            vb_ff;
   logic [bqs_pkg::SAMPLE_W-1:0]    idx_a_ff;
   logic [bqs_pkg::SAMPLE_W-1:0]    idx_b_ff;
   logic [PROD_W-1:0]               prod_ff;
   logic                            found_ff;
   logic                            found_in;
   logic [bqs_pkg::SAMPLE_W-1:0]    res_ff;
   logic [bqs_pkg::SAMPLE_W-1:0]    res_in;
   logic                            hit_now;

   // rank n-1 when the ratio is not below one, else n*num over den
   assign ratio_ge  = (ratio_num >= ratio_den);
   assign target_in = ratio_ge ? (PROD_W'(run_count) - PROD_W'(1))
                               : (PROD_W'(run_count) * PROD_W'(ratio_num));

   // target and scale latched once per run
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         mden_ff   <= ratio_ge ? bqs_pkg::RATIO_W'(1) : ratio_den;
         target_ff <= target_in;
      end
   end

   // stage a: cumulative count
   always_comb begin
      if (ctrl.start) begin
         run_in = '0;
      end else if (ctrl.shift) begin
         run_in = run_ff + head_count;
      end else begin
         run_in = run_ff;
      end
   end

   // stage b: scaled cumulative count
   always_ff @(posedge clock) begin
      idx_a_ff <= ctrl.bin;
      idx_b_ff <= idx_a_ff;
      prod_ff  <= PROD_W'(run_ff) * PROD_W'(mden_ff);
   end

   // first bin whose scaled count passes the target
   assign hit_now = vb_ff && !found_ff && (prod_ff > target_ff);

   always_comb begin
      found_in = found_ff;
      res_in   = res_ff;
      if (ctrl.start) begin
         found_in = 1'b0;
      end else if (hit_now) begin
         found_in = 1'b1;
         res_in   = idx_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= '0;
         va_ff    <= 1'b0;
         vb_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         run_ff   <= run_in;
         va_ff    <= ctrl.shift;
         vb_ff    <= va_ff;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   // top bin when nothing passed
   assign rank_value = found_ff ? res_ff
                     : (hit_now ? idx_b_ff : bqs_pkg::SAMPLE_W'(bqs_pkg::NUM_BINS - 1));

endmodule

/* design/byte_quantile_select_top.sv */
// ----------------------------------------------------------------------------
// byte_quantile_select_top
// Returns the sample of rank k from a run of unsigned byte samples, with
// k = floor(n*num/den), or n-1 when num >= den. Samples are taken one per
// cycle while the block collects, into a chain of 256 histogram cells, one
// per byte value; samples past MAX_SAMPLES in a run are dropped from the
// count. After the last beat of a run the block stops taking samples while
// it latches the rank target, shifts every cell past the chain head into
// the running sum (which also clears the histogram) and drains the sum and
// compare stages. The result then waits in an output register, so the next
// run's samples are accepted while it is still pending; a second result
// waits for the first to be taken.
// ----------------------------------------------------------------------------
module byte_quantile_select_top #(
   parameter int MAX_SAMPLES = bqs_pkg::MAX_SAMPLES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bqs_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bqs_pkg::SAMPLE_W-1:0]    rsp_quantile_value,
   input  logic                            csr_write_enable,
   input  logic [bqs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bqs_pkg::RATIO_W-1:0]     csr_write_data
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int NB    = bqs_pkg::NUM_BINS;

   bqs_pkg::bqs_state_type         state_ff;
   bqs_pkg::bqs_state_type         state_in;
   logic [bqs_pkg::RATIO_W-1:0]    num_ff;
   logic [bqs_pkg::RATIO_W-1:0]    den_ff;
   logic [CNT_W-1:0]               cnt_ff;
   logic [CNT_W-1:0]               cnt_in;
   logic [bqs_pkg::SAMPLE_W-1:0]   scan_idx_ff;
   logic                           rsp_valid_ff;
   logic [bqs_pkg::SAMPLE_W-1:0]   rsp_value_ff;
   logic                           accept;
   logic                           room;
   logic                           slot_free;
   logic                           shift;
   logic [CNT_W-1:0]               bin_count [0:NB];
   logic [bqs_pkg::SAMPLE_W-1:0]   rank_value;
   bqs_pkg::bqs_scan_ctrl_type     scan_ctrl;

   assign req_ready = (state_ff == bqs_pkg::ST_COLLECT);
   assign accept    = req_valid && req_ready;
   assign room      = (cnt_ff < CNT_W'(MAX_SAMPLES));
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign shift     = (state_ff == bqs_pkg::ST_SCAN);

   // ratio registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= bqs_pkg::RATIO_NUM_RESET;
         den_ff <= bqs_pkg::RATIO_DEN_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            bqs_pkg::CSR_RATIO_NUM: num_ff <= csr_write_data;
            bqs_pkg::CSR_RATIO_DEN: den_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // histogram chain; the tail shifts in zeros
   assign bin_count[NB] = '0;

   for (genvar i = 0; i < NB; i++) begin : g_cell
      bqs_cell #(
         .CNT_W(CNT_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .hit     (accept && room && (req_sample == bqs_pkg::SAMPLE_W'(i))),
         .shift   (shift),
         .shift_in(bin_count[i+1]),
         .count   (bin_count[i])
      );
   end

   // sample count of the current run
   always_comb begin
      if (state_ff == bqs_pkg::ST_CALC) begin
         cnt_in = '0;
      end else if (accept && room) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bqs_pkg::ST_COLLECT: begin
            if (accept && req_last) begin
               state_in = bqs_pkg::ST_CALC;
            end
         end
         bqs_pkg::ST_CALC:  state_in = bqs_pkg::ST_SCAN;
         bqs_pkg::ST_SCAN: begin
            if (scan_idx_ff == bqs_pkg::SAMPLE_W'(NB - 1)) begin
               state_in = bqs_pkg::ST_DRAIN;
            end
         end
         bqs_pkg::ST_DRAIN: state_in = bqs_pkg::ST_FINISH;
         bqs_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = bqs_pkg::ST_COLLECT;
            end
         end
         default: state_in = bqs_pkg::ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bqs_pkg::ST_COLLECT;
         cnt_ff      <= '0;
         scan_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         scan_idx_ff <= shift ? scan_idx_ff + bqs_pkg::SAMPLE_W'(1) : '0;
      end
   end

   // rank scan behind the chain head
   assign scan_ctrl.start = (state_ff == bqs_pkg::ST_CALC);
   assign scan_ctrl.shift = shift;
   assign scan_ctrl.bin   = scan_idx_ff;

   bqs_rank_scan #(
      .CNT_W(CNT_W)
   ) u_rank_scan (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (scan_ctrl),
      .head_count(bin_count[0]),
      .run_count (cnt_ff),
      .ratio_num (num_ff),
      .ratio_den (den_ff),
      .rank_value(rank_value)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == bqs_pkg::ST_FINISH) && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == bqs_pkg::ST_FINISH) && slot_free) begin
         rsp_value_ff <= rank_value;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quantile_value = rsp_value_ff;

endmodule

/* design/bqs_checker.sv */
// ----------------------------------------------------------------------------
// bqs_checker
// port-level checks of the byte quantile select block, bound to the top
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bqs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_last,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [bqs_pkg::SAMPLE_W-1:0] rsp_quantile_value
);

   // a stalled result beat holds
   `BQS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `BQS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready,
                    $stable(rsp_quantile_value))

   // the last beat of a run starts the rank scan
   `BQS_ASSERT_NEXT(a_last_stops_input, clock, reset,
                    req_valid && req_ready && req_last, !req_ready)

   // a new result only comes out of the rank scan
   `BQS_ASSERT_IMPL(a_rsp_after_scan, clock, reset, $rose(rsp_valid), $past(!req_ready))

endmodule

bind byte_quantile_select_top bqs_checker u_bqs_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks byte_quantile_select_top against its own histogram model. A short
// table of runs covers the rank extremes, a denominator of zero and the
// register extremes, then random runs under varying ratio settings follow,
// one of them longer than the sample limit. Beats go out on valid/ready
// with random gaps on both sides, and every quantile that comes back is
// compared with the oldest one predicted.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RANDOM_ITEMS  = 2000;
   localparam int STALL_LIMIT   = 20000;
   localparam int RANK_LATENCY  = 300;
   localparam int HOLD_CYCLES   = 2000;
   localparam int DIR_ROWS_N    = 27;
   // a small run limit keeps the over-long run short
   localparam int RUN_LIMIT     = 256;

   // one row of the directed table: a ratio write or one sample beat
   typedef struct packed {
      logic                         is_cfg;
      logic [bqs_pkg::RATIO_W-1:0]  num;
      logic [bqs_pkg::RATIO_W-1:0]  den;
      logic [bqs_pkg::SAMPLE_W-1:0] sample;
      logic                         last;
      logic                         typed;
      logic [bqs_pkg::SAMPLE_W-1:0] want;
   } dir_row_type;

   localparam dir_row_type DIR_ROWS [DIR_ROWS_N] = '{
      // reset ratio 1/2: single-sample runs at both ends, then a median
      '{1'b0, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'hFF, 1'b1, 1'b1, 8'hFF},
      '{1'b0, 16'h0000, 16'h0000, 8'h03, 1'b0, 1'b0, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'h01, 1'b0, 1'b0, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'h02, 1'b1, 1'b1, 8'h02},
      // zero numerator picks the minimum
      '{1'b1, 16'h0000, 16'hFFFF, 8'h00, 1'b0, 1'b0, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'd200, 1'b0, 1'b0, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'd3, 1'b0, 1'b0, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'd90, 1'b1, 1'b1, 8'd3},
      // numerator equal to denominator picks the maximum
      '{1'b1, 16'hFFFF, 16'hFFFF, 8'h00, 1'b0, 1'b0, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'd10, 1'b0, 1'b0, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'd250, 1'b0, 1'b0, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'd1, 1'b1, 1'b1, 8'd250},
      // zero denominator also picks the maximum
      '{1'b1, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'd44, 1'b0, 1'b0, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'd17, 1'b1, 1'b1, 8'd44},
      // ratio just below one
      '{1'b1, 16'hFFFE, 16'hFFFF, 8'h00, 1'b0, 1'b0, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'hAA, 1'b0, 1'b0, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'h55, 1'b0, 1'b0, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'h01, 1'b1, 1'b0, 8'h00},
      // smallest nonzero ratio
      '{1'b1, 16'h0001, 16'hFFFF, 8'h00, 1'b0, 1'b0, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'h80, 1'b0, 1'b0, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'h7F, 1'b1, 1'b0, 8'h00},
      // back to the reset ratio, with a duplicate
      '{1'b1, 16'h0001, 16'h0002, 8'h00, 1'b0, 1'b0, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'h09, 1'b0, 1'b0, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'h09, 1'b0, 1'b0, 8'h00},
      '{1'b0, 16'h0000, 16'h0000, 8'h04, 1'b1, 1'b0, 8'h00}
   };

   // block ports
   logic                           clock            = 1'b0;
   logic                           reset            = 1'b1;
   logic                           req_valid        = 1'b0;
   logic                           req_ready;
   logic [bqs_pkg::SAMPLE_W-1:0]   req_sample       = '0;
   logic                           req_last         = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready        = 1'b0;
   logic [bqs_pkg::SAMPLE_W-1:0]   rsp_quantile_value;
   logic                           csr_write_enable = 1'b0;
   logic [bqs_pkg::CSR_IDX_W-1:0]  csr_index        = bqs_pkg::CSR_RATIO_NUM;
   logic [bqs_pkg::RATIO_W-1:0]    csr_write_data   = '0;

   // histogram model and its ratio registers
   logic [12:0]                    bin_count [bqs_pkg::NUM_BINS];
   logic [12:0]                    run_len;
   logic [bqs_pkg::RATIO_W-1:0]    ratio_num = bqs_pkg::RATIO_NUM_RESET;
   logic [bqs_pkg::RATIO_W-1:0]    ratio_den = bqs_pkg::RATIO_DEN_RESET;
   logic [bqs_pkg::SAMPLE_W-1:0]   quantile_q [$];

   // pacing and bookkeeping
   int snd_idle_pct = 21;
   int rcv_idle_pct = 69;
   int hold_left    = 0;
   bit hold_req     = 1'b0;
   bit hold_done    = 1'b0;
   int fail_count   = 0;
   int quiet_cycles = 0;
   int random_items = 0;

   byte_quantile_select_top #(
      .MAX_SAMPLES(RUN_LIMIT)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_quantile_value (rsp_quantile_value),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #10 clock = ~clock;

   initial begin
      for (int v = 0; v < bqs_pkg::NUM_BINS; v++) bin_count[v] = '0;
      run_len = '0;
   end

   // send one sample beat; on acceptance count it and, on the last beat,
   // predict the quantile of the run and clear the histogram
   task automatic push_sample(input logic [bqs_pkg::SAMPLE_W-1:0] s, input logic l,
                              input logic typed,
                              input logic [bqs_pkg::SAMPLE_W-1:0] want);
      logic [63:0] rank_k;
      logic [31:0] acc;
      logic [bqs_pkg::SAMPLE_W-1:0] pick;
      bit found;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      req_last   <= l;
      do @(posedge clock); while (!req_ready);
      // samples beyond the run limit are dropped
      if (run_len < RUN_LIMIT) begin
         bin_count[s] = bin_count[s] + 13'd1;
         run_len = run_len + 13'd1;
      end
      if (l) begin
         if (ratio_num >= ratio_den) rank_k = 64'(run_len) - 64'd1;
         else rank_k = (64'(run_len) * 64'(ratio_num)) / 64'(ratio_den);
         // first value whose running count passes the rank
         acc = '0;
         pick = 8'hFF;
         found = 1'b0;
         for (int v = 0; v < bqs_pkg::NUM_BINS; v++) begin
            acc = acc + 32'(bin_count[v]);
            if (!found && 64'(acc) > rank_k) begin
               pick = bqs_pkg::SAMPLE_W'(v);
               found = 1'b1;
            end
            bin_count[v] = '0;
         end
         run_len = '0;
         quantile_q.push_back(typed ? want : pick);
      end
   endtask

   // let every pending quantile come back before touching the registers
   task automatic drain_results();
      req_valid <= 1'b0;
      while (quantile_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write both ratio registers on consecutive edges
   task automatic write_ratios(input logic [bqs_pkg::RATIO_W-1:0] num,
                               input logic [bqs_pkg::RATIO_W-1:0] den);
      csr_write_enable <= 1'b1;
      csr_index        <= bqs_pkg::CSR_RATIO_NUM;
      csr_write_data   <= num;
      @(posedge clock);
      csr_index        <= bqs_pkg::CSR_RATIO_DEN;
      csr_write_data   <= den;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      ratio_num = num;
      ratio_den = den;
   endtask

   // ratio values leaning toward the edges
   function automatic logic [bqs_pkg::RATIO_W-1:0] pick_ratio();
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h0001;
         3:       return 16'h0002;
         4, 5:    return bqs_pkg::RATIO_W'($urandom_range(1, 16));
         default: return bqs_pkg::RATIO_W'($urandom_range(65535));
      endcase
   endfunction

   // one run of samples drawn in a randomly chosen style
   task automatic send_run(input int len);
      int style;
      logic [bqs_pkg::SAMPLE_W-1:0] base;
      logic [bqs_pkg::SAMPLE_W-1:0] s;
      style = $urandom_range(3);
      base  = bqs_pkg::SAMPLE_W'($urandom_range(255));
      for (int i = 0; i < len; i++) begin
         case (style)
            0:       s = bqs_pkg::SAMPLE_W'($urandom_range(255));
            1:       s = base + bqs_pkg::SAMPLE_W'($urandom_range(3));
            2:       s = base;
            default: s = $urandom_range(1) ? 8'hFF : 8'h00;
         endcase
         push_sample(s, i == len - 1, 1'b0, '0);
      end
   endtask

   // stimulus
   initial begin
      int phase;
      int runs;
      int len;
      int r;
      bit long_done;
      phase = 0;
      long_done = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIR_ROWS[i]) begin
         if (DIR_ROWS[i].is_cfg) begin
            drain_results();
            write_ratios(DIR_ROWS[i].num, DIR_ROWS[i].den);
         end else begin
            push_sample(DIR_ROWS[i].sample, DIR_ROWS[i].last,
                        DIR_ROWS[i].typed, DIR_ROWS[i].want);
         end
      end

      // random phases, each under its own ratio setting
      while (random_items < RANDOM_ITEMS) begin
         drain_results();
         if (random_items < RANDOM_ITEMS / 3) begin
            snd_idle_pct = 21;
            rcv_idle_pct = 69;
         end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
            snd_idle_pct = 69;
            rcv_idle_pct = 21;
         end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         write_ratios(pick_ratio(), pick_ratio());
         // receiver holds off while this phase's runs keep coming
         if (phase == 1) hold_req = 1'b1;
         runs = $urandom_range(3, 8);
         for (int j = 0; j < runs; j++) begin
            // one run past the sample limit
            if (!long_done && phase == 4) begin
               long_done = 1'b1;
               len = RUN_LIMIT + $urandom_range(1, 40);
               send_run(len);
               random_items += len;
            end
            r = $urandom_range(99);
            if (r < 20) len = $urandom_range(1, 3);
            else if (r < 95) len = $urandom_range(4, 40);
            else len = $urandom_range(100, 300);
            send_run(len);
            random_items += len;
         end
         phase++;
      end

      // wind down
      req_valid <= 1'b0;
      while (quantile_q.size() != 0) @(posedge clock);
      repeat (RANK_LATENCY) @(posedge clock);
      if (quantile_q.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // receiver: random stalls, plus one long hold-off that backs the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // result check against the oldest predicted quantile
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (quantile_q.size() == 0) begin
            if (fail_count < 10)
               $display("tb: unexpected result beat, quantile_value %0d",
                        rsp_quantile_value);
            fail_count++;
         end else begin
            if (rsp_quantile_value !== quantile_q[0]) begin
               if (fail_count < 10)
                  $display("tb: quantile_value mismatch, expected %0d got %0d",
                           quantile_q[0], rsp_quantile_value);
               fail_count++;
            end
            void'(quantile_q.pop_front());
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

endmodule

/* byte_quantile_select_top.f */
+incdir+design
design/bqs_pkg.sv
design/bqs_cell.sv
design/bqs_rank_scan.sv
design/byte_quantile_select_top.sv
design/bqs_checker.sv
tb/tb_top.sv
